[rtl/fbmvn_pkg.sv]
package fbmvn_pkg;

    // field widths
    localparam int COORD_W = 26;
    localparam int DEPTH_W = 32;

    // build defaults
    localparam int DEF_OCTAVE_COUNT = 4;
    localparam int DEF_MAX_LEVELS   = 64;

    // hash constants
    localparam logic [31:0] HASH_M1 = 32'h7feb352d;
    localparam logic [31:0] HASH_M2 = 32'h846ca68b;
    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349663;
    localparam logic [31:0] PRIME_Z = 32'd83492791;

    // output mix weights, 0.65 and 0.35 in Q0.16
    localparam logic [15:0] MIX_N = 16'd42598;
    localparam logic [15:0] MIX_B = 16'd22938;

    // configuration registers
    typedef enum logic [1:0] {
        CFG_COORD_SCALE   = 2'd0,
        CFG_LEVEL_COUNT   = 2'd1,
        CFG_INVERT_LEVELS = 2'd2
    } t_cfg_index;

    localparam logic [15:0] RST_COORD_SCALE = 16'd7864;
    localparam logic [6:0]  RST_LEVEL_COUNT = 7'd10;

    // item payloads
    typedef struct packed {
        logic [9:0]  column;
        logic [9:0]  row;
        logic [31:0] depth;
    } t_pixel_in;

    typedef struct packed {
        logic [5:0]  level_index;
        logic [15:0] noise_value;
    } t_level_out;

    // quarter wave of 32767*sin, 33 points
    function automatic logic [14:0] quarter_sine(input logic [5:0] idx);
        logic [14:0] val;
        case (idx)
            6'd0:  val = 15'd0;
            6'd1:  val = 15'd1608;
            6'd2:  val = 15'd3212;
            6'd3:  val = 15'd4808;
            6'd4:  val = 15'd6393;
            6'd5:  val = 15'd7962;
            6'd6:  val = 15'd9512;
            6'd7:  val = 15'd11039;
            6'd8:  val = 15'd12539;
            6'd9:  val = 15'd14010;
            6'd10: val = 15'd15446;
            6'd11: val = 15'd16846;
            6'd12: val = 15'd18204;
            6'd13: val = 15'd19519;
            6'd14: val = 15'd20787;
            6'd15: val = 15'd22005;
            6'd16: val = 15'd23170;
            6'd17: val = 15'd24279;
            6'd18: val = 15'd25329;
            6'd19: val = 15'd26319;
            6'd20: val = 15'd27245;
            6'd21: val = 15'd28105;
            6'd22: val = 15'd28898;
            6'd23: val = 15'd29621;
            6'd24: val = 15'd30273;
            6'd25: val = 15'd30852;
            6'd26: val = 15'd31356;
            6'd27: val = 15'd31785;
            6'd28: val = 15'd32137;
            6'd29: val = 15'd32412;
            6'd30: val = 15'd32609;
            6'd31: val = 15'd32728;
            6'd32: val = 15'd32767;
            default: val = 15'd32767;
        endcase
        return val;
    endfunction

    // a + (b - a) * s / 2^16, floor; equals (a*(1-s) + b*s) >> 16
    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] s);
        logic signed [16:0] diff;
        logic signed [33:0] prod;
        diff = signed'({1'b0, b}) - signed'({1'b0, a});
        prod = 34'(diff) * 34'(signed'({1'b0, s}));
        return a + 16'(prod >>> 16);
    endfunction

endpackage

[rtl/fbmvn_octave.sv]
module fbmvn_octave #(
    parameter int OCT_SHIFT = 0
) (
    input  logic                          i_clk,
    input  logic [5:0]                    i_load,
    input  logic [fbmvn_pkg::COORD_W-1:0] i_bx,
    input  logic [fbmvn_pkg::COORD_W-1:0] i_by,
    input  logic [fbmvn_pkg::DEPTH_W-1:0] i_depth,
    output logic [15:0]                   o_value
);
    import fbmvn_pkg::*;

    localparam int XW = COORD_W + OCT_SHIFT;
    localparam int ZW = DEPTH_W + OCT_SHIFT;

    // octave coordinates
    logic [XW-1:0] w_x;
    logic [XW-1:0] w_yw;
    logic [XW-2:0] w_y;
    logic [ZW-1:0] w_z;
    logic [15:0]   w_t [3];
    logic [31:0]   w_x0, w_y0, w_z0;

    assign w_x  = XW'(i_bx) << OCT_SHIFT;
    assign w_yw = XW'(i_by) << OCT_SHIFT;
    assign w_y  = w_yw[XW-1:1];
    assign w_z  = ZW'(i_depth) << OCT_SHIFT;
    assign w_x0 = 32'(w_x[XW-1:16]);
    assign w_y0 = 32'(w_y[XW-2:16]);
    assign w_z0 = 32'(w_z[ZW-1:16]);
    assign w_t[0] = w_x[15:0];
    assign w_t[1] = w_y[15:0];
    assign w_t[2] = w_z[15:0];

    // stage a: lattice products and t squared
    logic [31:0] r_hx, r_hy, r_hz;
    logic [15:0] r_t  [3];
    logic [31:0] r_tt [3];

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_hx <= w_x0 * PRIME_X;
            r_hy <= w_y0 * PRIME_Y;
            r_hz <= w_z0 * PRIME_Z;
            for (int a = 0; a < 3; a++) begin
                r_t[a]  <= w_t[a];
                r_tt[a] <= 32'(w_t[a]) * 32'(w_t[a]);
            end
        end
    end

    // stage b: corner hash first round, fade cube and polynomial
    logic [31:0] n_m1 [8];
    logic [15:0] n_t3 [3];
    logic [19:0] n_r  [3];
    logic [31:0] r_m1 [8];
    logic [15:0] r_t3 [3];
    logic [19:0] r_r  [3];

    always_comb begin
        logic [31:0] h;
        logic [31:0] c3;
        logic [19:0] p;
        logic [35:0] pt;
        for (int c = 0; c < 8; c++) begin
            h = (r_hx + (c[0] ? PRIME_X : 32'd0))
              ^ (r_hy + (c[1] ? PRIME_Y : 32'd0))
              ^ (r_hz + (c[2] ? PRIME_Z : 32'd0));
            h = h ^ (h >> 16);
            n_m1[c] = h * HASH_M1;
        end
        for (int a = 0; a < 3; a++) begin
            c3 = 32'(r_tt[a][31:16]) * 32'(r_t[a]);
            n_t3[a] = c3[31:16];
            p = 20'd983040 - 20'(r_t[a]) * 20'd6;
            pt = 36'(p) * 36'(r_t[a]);
            n_r[a] = 20'd655360 - pt[35:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_m1 <= n_m1;
            r_t3 <= n_t3;
            r_r  <= n_r;
        end
    end

    // stage c: second hash round, fade weight
    logic [31:0] n_m2 [8];
    logic [15:0] n_s  [3];
    logic [31:0] r_m2 [8];
    logic [15:0] r_s  [3];

    always_comb begin
        logic [31:0] v;
        logic [35:0] sp;
        for (int c = 0; c < 8; c++) begin
            v = r_m1[c] ^ (r_m1[c] >> 15);
            n_m2[c] = v * HASH_M2;
        end
        for (int a = 0; a < 3; a++) begin
            sp = 36'(r_t3[a]) * 36'(r_r[a]);
            n_s[a] = (sp[35:32] != 4'd0) ? 16'hffff : sp[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_m2 <= n_m2;
            r_s  <= n_s;
        end
    end

    // stage d: corner values (top half of the final mix) blended along x
    logic [15:0] r_ax [4];
    logic [15:0] r_sy_d, r_sz_d, r_sz_e;

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            for (int j = 0; j < 4; j++) begin
                r_ax[j] <= blend(r_m2[2*j][31:16], r_m2[2*j+1][31:16], r_s[0]);
            end
            r_sy_d <= r_s[1];
            r_sz_d <= r_s[2];
        end
    end

    // stage e: blend along y
    logic [15:0] r_b0, r_b1;

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r_b0   <= blend(r_ax[0], r_ax[1], r_sy_d);
            r_b1   <= blend(r_ax[2], r_ax[3], r_sy_d);
            r_sz_e <= r_sz_d;
        end
    end

    // stage f: blend along z
    always_ff @(posedge i_clk) begin
        if (i_load[5]) begin
            o_value <= blend(r_b0, r_b1, r_sz_e);
        end
    end

endmodule

[rtl/fbm_value_noise_levels.sv]
// Fractal value noise shading level, one pixel item in, one level item out.
// Input channel i_in_valid / o_in_ready carries column, row and Q16.16 depth;
// output channel o_out_valid / i_out_ready carries the level index and the
// normalized Q0.16 noise value. Configuration is a plain write port (i_cfg_we,
// i_cfg_index, i_cfg_data), to be written by the user only while no item is in
// flight; the block does not enforce this. With no receiver stall, throughput is
// one item per cycle, set by the 13-stage pipeline (scale, six hash/fade/blend
// stages per octave lane, divide and correct, sine lookup, interpolate, mix,
// level). Every octave has its own lane, so the octave count costs area only.
// Reset clears all stage valid bits and loads the register defaults
// (scale 7864, 10 levels, no inversion). When the receiver stalls, each
// stage holds only while the stage after it is full, so bubbles close up
// and the input keeps being accepted until every stage holds an item.
module fbm_value_noise_levels #(
    parameter int OCTAVE_COUNT = fbmvn_pkg::DEF_OCTAVE_COUNT,
    parameter int MAX_LEVELS   = fbmvn_pkg::DEF_MAX_LEVELS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  fbmvn_pkg::t_pixel_in   i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output fbmvn_pkg::t_level_out  o_out_data,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data
);
    import fbmvn_pkg::*;

    localparam int NS   = 13;
    localparam int DIV  = (1 << OCTAVE_COUNT) - 1;
    localparam int MW   = 16 + OCTAVE_COUNT;
    localparam longint RECIP = (64'd1 << MW) / DIV;

    // configuration registers
    logic [15:0] r_coord_scale;
    logic [6:0]  r_level_count;
    logic        r_invert_levels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord_scale   <= RST_COORD_SCALE;
            r_level_count   <= RST_LEVEL_COUNT;
            r_invert_levels <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_COORD_SCALE:   r_coord_scale   <= i_cfg_data;
                CFG_LEVEL_COUNT:   r_level_count   <= i_cfg_data[6:0];
                CFG_INVERT_LEVELS: r_invert_levels <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage valid bits and per-stage load enables
    logic [NS:1] r_vld;
    logic [NS:1] w_ld;

    always_comb begin
        w_ld[NS] = !r_vld[NS] || i_out_ready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_ld[1];
    assign o_out_valid = r_vld[NS];

    // stage 1: scaled coordinates
    logic [COORD_W-1:0] r_bx, r_by;
    logic [DEPTH_W-1:0] r_depth;

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r_bx    <= COORD_W'(i_in_data.column) * COORD_W'(r_coord_scale);
            r_by    <= COORD_W'(i_in_data.row) * COORD_W'(r_coord_scale);
            r_depth <= i_in_data.depth;
        end
    end

    // stages 2 to 7: one lane per octave
    logic [15:0] w_oct_val [OCTAVE_COUNT];

    for (genvar g = 0; g < OCTAVE_COUNT; g++) begin : g_octave
        fbmvn_octave #(
            .OCT_SHIFT (g)
        ) u_octave (
            .i_clk   (i_clk),
            .i_load  (w_ld[7:2]),
            .i_bx    (r_bx),
            .i_by    (r_by),
            .i_depth (r_depth),
            .o_value (w_oct_val[g])
        );
    end

    // stage 8: weighted octave sum, rounded, reciprocal estimate of the quotient
    logic [MW-1:0]   n_m;
    logic [2*MW:0]   n_qprod;
    logic [MW-1:0]   r_m;
    logic [MW-1:0]   r_qe;

    always_comb begin
        n_m = MW'(DIV >> 1);
        for (int i = 0; i < OCTAVE_COUNT; i++) begin
            n_m = n_m + (MW'(w_oct_val[i]) << (OCTAVE_COUNT - 1 - i));
        end
        n_qprod = (2*MW+1)'(n_m) * (2*MW+1)'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[8]) begin
            r_m  <= n_m;
            r_qe <= n_qprod[2*MW-1:MW];
        end
    end

    // stage 9: quotient correction and saturation
    logic [MW+OCTAVE_COUNT-1:0] w_qd;
    logic [MW-1:0]              w_rem;
    logic [MW-1:0]              w_q;
    logic [15:0]                r_n9;

    assign w_qd  = ((MW+OCTAVE_COUNT)'(r_qe) << OCTAVE_COUNT) - (MW+OCTAVE_COUNT)'(r_qe);
    assign w_rem = r_m - w_qd[MW-1:0];
    assign w_q   = r_qe + MW'(w_rem >= MW'(DIV));

    always_ff @(posedge i_clk) begin
        if (w_ld[9]) begin
            r_n9 <= (w_q > MW'(16'hffff)) ? 16'hffff : w_q[15:0];
        end
    end

    // stage 10: band phase, sine table reads, noise weight
    logic [15:0] w_phase;
    logic [14:0] w_pos;
    logic [5:0]  w_tidx;
    logic [5:0]  w_tidx1;
    logic [14:0] r_q_lo, r_q_hi;
    logic [8:0]  r_frac;
    logic        r_neg;
    logic [31:0] r_nprod10;
    logic [15:0] r_n10;

    assign w_phase = r_n9 + (r_n9 << 2);
    assign w_pos   = w_phase[14] ? (15'd16384 - 15'(w_phase[13:0])) : 15'(w_phase[13:0]);
    assign w_tidx  = w_pos[14:9];
    assign w_tidx1 = (w_tidx >= 6'd32) ? 6'd32 : w_tidx + 6'd1;

    always_ff @(posedge i_clk) begin
        if (w_ld[10]) begin
            r_q_lo    <= quarter_sine(w_tidx);
            r_q_hi    <= quarter_sine(w_tidx1);
            r_frac    <= w_pos[8:0];
            r_neg     <= w_phase[15];
            r_nprod10 <= 32'(r_n9) * 32'(MIX_N);
            r_n10     <= r_n9;
        end
    end

    // stage 11: sine interpolation and band term
    logic [23:0] w_iprod;
    logic [14:0] w_sine;
    logic [16:0] r_band;
    logic [31:0] r_nprod11;
    logic [15:0] r_n11;

    assign w_iprod = 24'(r_q_hi - r_q_lo) * 24'(r_frac);
    assign w_sine  = r_q_lo + w_iprod[23:9];

    always_ff @(posedge i_clk) begin
        if (w_ld[11]) begin
            r_band    <= r_neg ? (17'd32768 - 17'(w_sine)) : (17'd32768 + 17'(w_sine));
            r_nprod11 <= r_nprod10;
            r_n11     <= r_n10;
        end
    end

    // stage 12: mix of noise and band
    logic [32:0] w_mix;
    logic [15:0] r_v;
    logic [15:0] r_n12;

    assign w_mix = 33'(r_nprod11) + 33'(r_band) * 33'(MIX_B) + 33'd32768;

    always_ff @(posedge i_clk) begin
        if (w_ld[12]) begin
            r_v   <= (w_mix[32:16] > 17'd65535) ? 16'hffff : w_mix[31:16];
            r_n12 <= r_n11;
        end
    end

    // stage 13: level quantization, clamp, mirror
    logic [8:0]  w_levels;
    logic [7:0]  w_lv;
    logic [24:0] w_lprod;
    logic [7:0]  w_idx;
    logic [7:0]  w_idx_c;

    always_comb begin
        w_levels = 9'(r_level_count);
        if (w_levels < 9'd2) begin
            w_levels = 9'd2;
        end
        if (w_levels > 9'(MAX_LEVELS)) begin
            w_levels = 9'(MAX_LEVELS);
        end
        w_lv    = 8'(w_levels - 9'd1);
        w_lprod = 25'(r_v) * 25'(w_lv) + 25'd32768;
        w_idx   = w_lprod[23:16];
        w_idx_c = (w_lprod[24] || w_idx > w_lv) ? w_lv : w_idx;
        if (r_invert_levels) begin
            w_idx_c = w_lv - w_idx_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[13]) begin
            o_out_data.level_index <= w_idx_c[5:0];
            o_out_data.noise_value <= r_n12;
        end
    end

endmodule

[dv/fbm_value_noise_levels_checker.sv]
module fbm_value_noise_levels_checker
    import fbmvn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_pixel_in   i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_level_out  i_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OCTAVES = 4;
    localparam int LEVEL_MAX = 64;

    logic [15:0] scale_reg;
    logic [6:0]  levels_reg;
    logic        invert_reg;
    t_level_out  level_queue[$];

    // avalanche hash of a corner, top 16 bits
    function automatic logic [15:0] corner_value(logic [31:0] xi, logic [31:0] yi,
                                                 logic [31:0] zi);
        logic [31:0] h;
        h = (xi * PRIME_X) ^ (yi * PRIME_Y) ^ (zi * PRIME_Z);
        h = h ^ (h >> 16);
        h = h * HASH_M1;
        h = h ^ (h >> 15);
        h = h * HASH_M2;
        h = h ^ (h >> 16);
        return h[31:16];
    endfunction

    function automatic logic [63:0] quintic(logic [63:0] t);
        logic [63:0] t3, p, r, s;
        t3 = (((t * t) >> 16) * t) >> 16;
        p = 64'd983040 - 64'd6 * t;
        r = 64'd655360 - ((p * t) >> 16);
        s = (t3 * r) >> 16;
        return (s > 65535) ? 64'd65535 : s;
    endfunction

    function automatic logic [63:0] lerp16(logic [63:0] a, logic [63:0] b, logic [63:0] s);
        return (a * (64'd65536 - s) + b * s) >> 16;
    endfunction

    function automatic logic [63:0] octave_noise(logic [63:0] x, logic [63:0] y,
                                                 logic [63:0] z);
        logic [31:0] x0, y0, z0, x1, y1, z1;
        logic [63:0] sx, sy, sz, a00, a10, a01, a11;
        x0 = x[47:16]; y0 = y[47:16]; z0 = z[47:16];
        x1 = x0 + 1; y1 = y0 + 1; z1 = z0 + 1;
        sx = quintic(x & 64'hFFFF);
        sy = quintic(y & 64'hFFFF);
        sz = quintic(z & 64'hFFFF);
        a00 = lerp16(corner_value(x0, y0, z0), corner_value(x1, y0, z0), sx);
        a10 = lerp16(corner_value(x0, y1, z0), corner_value(x1, y1, z0), sx);
        a01 = lerp16(corner_value(x0, y0, z1), corner_value(x1, y0, z1), sx);
        a11 = lerp16(corner_value(x0, y1, z1), corner_value(x1, y1, z1), sx);
        return lerp16(lerp16(a00, a10, sy), lerp16(a01, a11, sy), sz);
    endfunction

    function automatic logic [31:0] sine_band(logic [31:0] n);
        logic [31:0] phase, w, pos, i, f, s;
        phase = (n * 5) & 32'hFFFF;
        w = phase & 32'h3FFF;
        pos = phase[14] ? (32'd16384 - w) : w;
        i = pos >> 9;
        f = pos & 32'd511;
        if (i >= 32) begin
            s = 32767;
        end else begin
            s = quarter_sine(i[5:0])
                + (((quarter_sine(i[5:0] + 6'd1) - quarter_sine(i[5:0])) * f) >> 9);
        end
        return phase[15] ? (32'd32768 - s) : (32'd32768 + s);
    endfunction

    function automatic t_level_out shade_pixel(t_pixel_in px);
        logic [63:0] bx, by, sum, n, v, lv, idx;
        logic [31:0] lc;
        t_level_out res;
        bx = 64'(px.column) * scale_reg;
        by = 64'(px.row) * scale_reg;
        sum = 0;
        for (int i = 0; i < OCTAVES; i++) begin
            sum += octave_noise(bx << i, (by << i) >> 1, 64'(px.depth) << i)
                   << (OCTAVES - 1 - i);
        end
        n = (sum + 7) / 15;
        if (n > 65535) n = 65535;
        v = (64'd42598 * n + 64'd22938 * sine_band(n[31:0]) + 32768) >> 16;
        if (v > 65535) v = 65535;
        lc = levels_reg;
        if (lc < 2) lc = 2;
        if (lc > LEVEL_MAX) lc = LEVEL_MAX;
        lv = lc - 1;
        idx = (v * lv + 32768) >> 16;
        if (idx > lv) idx = lv;
        if (invert_reg) idx = lv - idx;
        res.level_index = idx[5:0];
        res.noise_value = n[15:0];
        return res;
    endfunction

    assign o_pending = level_queue.size();

    // register shadow, prediction and comparison
    always @(posedge i_clk) begin
        t_level_out want;
        if (!i_rst_n) begin
            scale_reg <= RST_COORD_SCALE;
            levels_reg <= RST_LEVEL_COUNT;
            invert_reg <= 1'b0;
            level_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_COORD_SCALE:   scale_reg <= i_cfg_data;
                    CFG_LEVEL_COUNT:   levels_reg <= i_cfg_data[6:0];
                    CFG_INVERT_LEVELS: invert_reg <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) level_queue.push_back(shade_pixel(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (level_queue.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %p",
                             $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = level_queue.pop_front();
                    if (want.level_index !== i_out_data.level_index
                        || want.noise_value !== i_out_data.noise_value) begin
                        $display("%0t: expected level %0d noise %0d, actual level %0d noise %0d",
                                 $time, want.level_index, want.noise_value,
                                 i_out_data.level_index, i_out_data.noise_value);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[dv/fbm_value_noise_levels_test.sv]
module fbm_value_noise_levels_test;
    import fbmvn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    t_pixel_in   in_data = '0;
    logic        out_valid;
    logic        out_ready = 0;
    t_level_out  out_data;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = CFG_COORD_SCALE;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          pending;

    always #5 i_clk = ~i_clk;

    fbm_value_noise_levels DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    fbm_value_noise_levels_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one pixel item, with an optional gap first; valid stays up after accept
    task automatic send_pixel(logic [9:0] col, logic [9:0] row, logic [31:0] dep,
                              bit gaps);
        int g;
        g = gaps ? gap_length() : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= '{column: col, row: row, depth: dep};
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // stop sending and wait for every expected item
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // receiver stalls
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            g = gap_length();
            if (g == 0 && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else begin
                out_ready <= (g == 0);
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #20ms;
        $display("fbm_value_noise_levels_test failed");
        $finish;
    end

    // stimulus
    initial begin
        logic [15:0] scales[4];
        logic [6:0] levels[4];
        scales = '{16'd1, 16'd65535, 16'd7864, 16'd300};
        levels = '{7'd2, 7'd64, 7'd0, 7'd127};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed corners at reset defaults
        send_pixel(10'd0, 10'd0, 32'd0, 0);
        send_pixel(10'd1023, 10'd1023, 32'hFFFF_FFFF, 0);
        send_pixel(10'd1023, 10'd0, 32'h0000_FFFF, 0);
        send_pixel(10'd0, 10'd1023, 32'hFFFF_0000, 0);
        send_pixel(10'h155, 10'h2AA, 32'h5555_AAAA, 0);
        send_pixel(10'h2AA, 10'h155, 32'hAAAA_5555, 0);
        drain();
        // zero scale and extremes of level count and inversion
        write_reg(CFG_COORD_SCALE, 16'd0);
        write_reg(CFG_LEVEL_COUNT, 16'd1);
        write_reg(CFG_INVERT_LEVELS, 16'd1);
        for (int i = 0; i < 8; i++)
            send_pixel(10'($urandom), 10'($urandom), $urandom, 0);
        drain();
        write_reg(CFG_INVERT_LEVELS, 16'hFFFE);
        // random phases across settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_COORD_SCALE, ph < 4 ? scales[ph] : 16'($urandom_range(1, 65535)));
            write_reg(CFG_LEVEL_COUNT, ph < 4 ? 16'(levels[ph]) : 16'($urandom_range(2, 64)));
            write_reg(CFG_INVERT_LEVELS, 16'(ph[0]));
            for (int i = 0; i < 240; i++) begin
                send_pixel(10'($urandom), 10'($urandom), $urandom, 1);
                if (i == 120) begin
                    in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain();
        end
        if (fail_count == 0) begin
            $display("fbm_value_noise_levels_test passed");
        end else begin
            $display("fbm_value_noise_levels_test failed");
        end
        $finish;
    end
endmodule
